// File: hdl/dual_queue_shortest_join_top_assert.svh
// assertion macros for the dual queue block
`ifndef DUAL_QUEUE_SHORTEST_JOIN_TOP_ASSERT_SVH
`define DUAL_QUEUE_SHORTEST_JOIN_TOP_ASSERT_SVH

// same-cycle implication, off while reset is high
`define DQSJ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dqsj assertion failed");

// next-cycle implication, off while reset is high
`define DQSJ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dqsj assertion failed");

`endif

// File: hdl/dqsj_pkg.sv
package dqsj_pkg;

   // default sizes
   localparam int DEPTH_DEF   = 16;
   localparam int VALUE_W_DEF = 16;

   // result field widths
   localparam int FILL_W    = 5;
   localparam int OUTCOME_W = 3;

   // outcome codes
   localparam logic [OUTCOME_W-1:0] OUT_ADD0 = OUTCOME_W'(0);
   localparam logic [OUTCOME_W-1:0] OUT_ADD1 = OUTCOME_W'(1);
   localparam logic [OUTCOME_W-1:0] OUT_FULL = OUTCOME_W'(2);
   localparam logic [OUTCOME_W-1:0] OUT_DEL0 = OUTCOME_W'(3);
   localparam logic [OUTCOME_W-1:0] OUT_DEL1 = OUTCOME_W'(4);
   localparam logic [OUTCOME_W-1:0] OUT_NONE = OUTCOME_W'(5);

   // item kinds
   localparam logic KIND_ADD    = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // per-queue control from the arbiter
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctrl_type;

endpackage

// File: hdl/dqsj_fifo.sv
module dqsj_fifo
   import dqsj_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_W_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  fifo_ctrl_type                  ctrl,
   input  logic [VALUE_WIDTH-1:0]         wr_value,
   output logic [VALUE_WIDTH-1:0]         head_value,
   output logic [$clog2(DEPTH+1)-1:0]     fill
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [VALUE_WIDTH-1:0] mem [DEPTH];

   logic [PTR_W-1:0]       head_ff, head_in;
   logic [PTR_W-1:0]       tail_ff, tail_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [VALUE_WIDTH-1:0] rd_ff;
   logic                   byp_ff, byp_in;
   logic [VALUE_WIDTH-1:0] byp_value_ff;

   // pointer and count updates, wrap at the last slot
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctrl.push) begin
         tail_in  = (tail_ff == LAST) ? '0 : tail_ff + PTR_W'(1);
         count_in = count_ff + CNT_W'(1);
      end
      if (ctrl.pop) begin
         head_in  = (head_ff == LAST) ? '0 : head_ff + PTR_W'(1);
         count_in = count_ff - CNT_W'(1);
      end
   end

   // a push into an empty queue lands on the head slot
   assign byp_in = ctrl.push && (tail_ff == head_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         byp_ff   <= byp_in;
      end
   end

   // storage: one write port, registered head read
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail_ff] <= wr_value;
      end
      rd_ff        <= mem[head_in];
      byp_value_ff <= wr_value;
   end

   assign head_value = byp_ff ? byp_value_ff : rd_ff;
   assign fill       = count_ff;

endmodule

// File: hdl/dual_queue_shortest_join_top.sv
// an input transfer reaches its result through the input register, then the result register
// throughput: one item per cycle while rsp_stall is low; each queue updates in a single pass on its head register
// an input transfer is taken while a result waits, as long as the input register is free
// reset clears queue pointers, fill counts and both valid flags; stored values are not cleared
module dual_queue_shortest_join_top
   import dqsj_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_W_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [OUTCOME_W-1:0]   rsp_outcome,
   output logic [FILL_W-1:0]      rsp_fill_zero,
   output logic [FILL_W-1:0]      rsp_fill_one
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic                   in_valid_ff, in_valid_in;
   logic                   in_kind_ff;
   logic [VALUE_WIDTH-1:0] in_value_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUTCOME_W-1:0]   outcome_ff, outcome_in;
   logic [FILL_W-1:0]      fill_zero_ff, fill_one_ff;

   fifo_ctrl_type          ctrl_zero, ctrl_one;
   logic [VALUE_WIDTH-1:0] head_zero, head_one;
   logic [CNT_W-1:0]       count_zero, count_one;
   logic [CNT_W-1:0]       fill_zero_nx, fill_one_nx;
   logic                   advance, take;
   logic                   match_zero, match_one;

   // handshake: item moves on when the result slot is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // an empty queue never matches
   assign match_zero = (count_zero != '0) && (head_zero == in_value_ff);
   assign match_one  = (count_one != '0) && (head_one == in_value_ff);

   // shortest-queue join and head match
   always_comb begin
      ctrl_zero   = '0;
      ctrl_one    = '0;
      fill_zero_nx = count_zero;
      fill_one_nx  = count_one;
      outcome_in  = OUT_NONE;
      unique case (in_kind_ff)
         KIND_ADD: begin
            priority if (count_zero == FULL_CNT && count_one == FULL_CNT) begin
               outcome_in = OUT_FULL;
            end else if (count_zero <= count_one) begin
               ctrl_zero.push = advance;
               fill_zero_nx   = count_zero + CNT_W'(1);
               outcome_in     = OUT_ADD0;
            end else begin
               ctrl_one.push = advance;
               fill_one_nx   = count_one + CNT_W'(1);
               outcome_in    = OUT_ADD1;
            end
         end
         KIND_REMOVE: begin
            priority if (match_zero) begin
               ctrl_zero.pop = advance;
               fill_zero_nx  = count_zero - CNT_W'(1);
               outcome_in    = OUT_DEL0;
            end else if (match_one) begin
               ctrl_one.pop = advance;
               fill_one_nx  = count_one - CNT_W'(1);
               outcome_in   = OUT_DEL1;
            end else begin
               outcome_in = OUT_NONE;
            end
         end
         default: begin
            outcome_in = OUT_NONE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input and result payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         in_kind_ff  <= req_kind;
         in_value_ff <= req_value;
      end
      if (advance) begin
         outcome_ff   <= outcome_in;
         fill_zero_ff <= FILL_W'(fill_zero_nx);
         fill_one_ff  <= FILL_W'(fill_one_nx);
      end
   end

   dqsj_fifo #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_fifo_zero (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl_zero),
      .wr_value   (in_value_ff),
      .head_value (head_zero),
      .fill       (count_zero)
   );

   dqsj_fifo #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_fifo_one (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl_one),
      .wr_value   (in_value_ff),
      .head_value (head_one),
      .fill       (count_one)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_outcome   = outcome_ff;
   assign rsp_fill_zero = fill_zero_ff;
   assign rsp_fill_one  = fill_one_ff;

endmodule

// File: hdl/dqsj_checker.sv
`include "dual_queue_shortest_join_top_assert.svh"

module dqsj_checker
   import dqsj_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [OUTCOME_W-1:0] rsp_outcome,
   input logic [FILL_W-1:0]    rsp_fill_zero,
   input logic [FILL_W-1:0]    rsp_fill_one
);

   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

   // no result right after reset
   `DQSJ_ASSERT_NOW(a_quiet_after_reset, clock, reset, $past(reset), !rsp_valid)

   // only defined outcome codes
   `DQSJ_ASSERT_NOW(a_outcome_code, clock, reset, rsp_valid, rsp_outcome <= OUT_NONE)

   // a refused add means both queues were full
   `DQSJ_ASSERT_NOW(a_full_refuse, clock, reset, rsp_valid && rsp_outcome == OUT_FULL, rsp_fill_zero == FULL_FILL && rsp_fill_one == FULL_FILL)

   // a stalled result transfer holds
   `DQSJ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_outcome) && $stable(rsp_fill_zero) && $stable(rsp_fill_one))

endmodule

bind dual_queue_shortest_join_top dqsj_checker #(
   .DEPTH (DEPTH)
) u_dqsj_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_outcome   (rsp_outcome),
   .rsp_fill_zero (rsp_fill_zero),
   .rsp_fill_one  (rsp_fill_one)
);

// File: tb/sv/tb_dual_queue_shortest_join_top.sv
`timescale 1ns / 1ps

module tb_dual_queue_shortest_join_top;
   import dqsj_pkg::*;

   localparam int DEPTH       = DEPTH_DEF;
   localparam int VW          = VALUE_W_DEF;
   localparam int ITEM_COUNT  = 1500;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_LINES   = 40;
   localparam int CODE_COUNT  = int'(OUT_NONE) + 1;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic [FILL_W-1:0]    fill_zero;
      logic [FILL_W-1:0]    fill_one;
   } join_result_type;

   // mirrors both queues and holds the results still owed by the block
   class dual_queue_scoreboard;
      logic [VW-1:0]   mirror_zero[$];
      logic [VW-1:0]   mirror_one[$];
      join_result_type due_results[$];
      int              errors;
      int              checked;
      int              outcome_hits[CODE_COUNT];

      function new();
         errors  = 0;
         checked = 0;
         foreach (outcome_hits[i]) outcome_hits[i] = 0;
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      task report(string what);
         if (errors < MAX_LINES) $display("%0t ns: mismatch: %s", $time, what);
         errors++;
      endtask

      // join-shortest-queue on add, first matching head on remove
      function void apply_request(logic kind, logic [VW-1:0] value);
         join_result_type r;
         if (kind == KIND_ADD) begin
            if (mirror_zero.size() >= DEPTH && mirror_one.size() >= DEPTH) begin
               r.outcome = OUT_FULL;
            end else if (mirror_zero.size() <= mirror_one.size()) begin
               mirror_zero.push_back(value);
               r.outcome = OUT_ADD0;
            end else begin
               mirror_one.push_back(value);
               r.outcome = OUT_ADD1;
            end
         end else begin
            if (mirror_zero.size() != 0 && mirror_zero[0] == value) begin
               void'(mirror_zero.pop_front());
               r.outcome = OUT_DEL0;
            end else if (mirror_one.size() != 0 && mirror_one[0] == value) begin
               void'(mirror_one.pop_front());
               r.outcome = OUT_DEL1;
            end else begin
               r.outcome = OUT_NONE;
            end
         end
         r.fill_zero = FILL_W'(mirror_zero.size());
         r.fill_one  = FILL_W'(mirror_one.size());
         outcome_hits[int'(r.outcome)]++;
         due_results.push_back(r);
      endfunction

      task check_response(logic [OUTCOME_W-1:0] outcome, logic [FILL_W-1:0] fill_zero,
                          logic [FILL_W-1:0] fill_one);
         join_result_type e;
         if (due_results.size() == 0) begin
            report("result transfer with no result pending");
         end else begin
            e = due_results.pop_front();
            checked++;
            if (outcome !== e.outcome)
               report($sformatf("outcome got %0d exp %0d", outcome, e.outcome));
            if (fill_zero !== e.fill_zero)
               report($sformatf("fill_zero got %0d exp %0d", fill_zero, e.fill_zero));
            if (fill_one !== e.fill_one)
               report($sformatf("fill_one got %0d exp %0d", fill_one, e.fill_one));
         end
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_kind;
   logic [VW-1:0]        req_value;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [OUTCOME_W-1:0] rsp_outcome;
   logic [FILL_W-1:0]    rsp_fill_zero;
   logic [FILL_W-1:0]    rsp_fill_one;

   dual_queue_scoreboard board = new();
   int sent;

   dual_queue_shortest_join_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_outcome   (rsp_outcome),
      .rsp_fill_zero (rsp_fill_zero),
      .rsp_fill_one  (rsp_fill_one)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_dual_queue_shortest_join_top: errors");
      $finish;
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.apply_request(req_kind, req_value);
         if (rsp_valid && !rsp_stall)
            board.check_response(rsp_outcome, rsp_fill_zero, rsp_fill_one);
      end
   end

   // result side stalls: short bursts, a few long ones, and free-running stretches
   initial begin : stall_driver
      int hold;
      int r;
      hold      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               rsp_stall <= 1'b0;
               hold = $urandom_range(0, 12);
            end else if (r < 55) begin
               rsp_stall <= 1'b0;
               hold = $urandom_range(40, 120);
            end else if (r < 92) begin
               rsp_stall <= 1'b1;
               hold = $urandom_range(0, 2);
            end else begin
               rsp_stall <= 1'b1;
               hold = $urandom_range(8, 40);
            end
         end
      end
   end

   // one transfer on the request side, then an optional idle gap
   task automatic send_item(input logic kind, input logic [VW-1:0] value, input int gap);
      req_kind  <= kind;
      req_value <= value;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      sent++;
   endtask

   // stop sending until every owed result has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // mostly full-range values, with zero, all ones and a tiny pool for equal heads
   function automatic logic [VW-1:0] pick_value();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 7) return VW'($urandom_range(1, 4));
      return VW'($urandom);
   endfunction

   // mostly a live head value; otherwise noise or a head with one bit flipped
   function automatic logic [VW-1:0] remove_value();
      logic [VW-1:0] head;
      int            r;
      r = $urandom_range(0, 9);
      if (board.mirror_zero.size() == 0 && board.mirror_one.size() == 0) return pick_value();
      if (board.mirror_zero.size() == 0) head = board.mirror_one[0];
      else if (board.mirror_one.size() == 0) head = board.mirror_zero[0];
      else if ($urandom_range(0, 1) == 0) head = board.mirror_zero[0];
      else head = board.mirror_one[0];
      if (r < 8) return head;
      if (r == 8) return pick_value();
      return head ^ (VW'(1) << $urandom_range(0, VW - 1));
   endfunction

   // stimulus
   initial begin : stimulus
      int  round;
      int  add_pct;
      int  len;
      bit  quiet;
      logic [VW-1:0] v;
      round     = 0;
      sent      = 0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_kind  = KIND_ADD;
      req_value = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: removes on empty queues, zero and all-ones values,
      // equal heads, no-match removes
      send_item(KIND_REMOVE, VW'(1), 0);
      send_item(KIND_REMOVE, '0, 0);
      send_item(KIND_ADD, '0, 0);
      send_item(KIND_ADD, '1, 0);
      send_item(KIND_REMOVE, '1, 0);
      send_item(KIND_REMOVE, '0, 1);
      send_item(KIND_ADD, VW'(7), 0);
      send_item(KIND_ADD, VW'(7), 0);
      send_item(KIND_REMOVE, VW'(7), 0);
      send_item(KIND_REMOVE, VW'(7), 2);
      send_item(KIND_ADD, VW'(16'hAAAA), 0);
      send_item(KIND_ADD, VW'(16'h5555), 0);
      send_item(KIND_REMOVE, VW'(16'h1234), 0);
      send_item(KIND_REMOVE, VW'(16'h5555), 0);
      send_item(KIND_REMOVE, VW'(16'hAAAA), 0);
      hold_until_drained();

      // random rounds: fill-heavy, drain-heavy and mixed
      while (sent < ITEM_COUNT) begin
         case ($urandom_range(0, 2))
            0: add_pct = 85;
            1: add_pct = 15;
            default: add_pct = 50;
         endcase
         quiet = ($urandom_range(0, 4) == 0);
         len   = $urandom_range(20, 70);
         repeat (len) begin
            if ($urandom_range(0, 99) < add_pct) begin
               v = pick_value();
               send_item(KIND_ADD, v, pick_gap(quiet));
            end else begin
               v = remove_value();
               send_item(KIND_REMOVE, v, pick_gap(quiet));
            end
         end
         round++;
         if (round % 6 == 0) hold_until_drained();
      end

      hold_until_drained();
      repeat (8) @(negedge clock);

      $display("covered %0d transfers: %0d added to q0, %0d added to q1, %0d refused as full",
               sent, board.outcome_hits[int'(OUT_ADD0)], board.outcome_hits[int'(OUT_ADD1)],
               board.outcome_hits[int'(OUT_FULL)]);
      $display("removes: %0d from q0, %0d from q1, %0d without a match; %0d results checked",
               board.outcome_hits[int'(OUT_DEL0)], board.outcome_hits[int'(OUT_DEL1)],
               board.outcome_hits[int'(OUT_NONE)], board.checked);
      if (board.errors == 0) begin
         $display("tb_dual_queue_shortest_join_top: clean");
      end else begin
         $display("tb_dual_queue_shortest_join_top: errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/dqsj_pkg.sv
hdl/dqsj_fifo.sv
hdl/dual_queue_shortest_join_top.sv
hdl/dqsj_checker.sv
tb/sv/tb_dual_queue_shortest_join_top.sv
